### rtl/core/dkvlp_pkg.sv
// Shared types, codes and helpers for the dollar key/value line parser.
package dkvlp_pkg;

    localparam int QDepth = 3;
    localparam int CntW   = $clog2(QDepth + 1);

    localparam logic [7:0] ChDollar    = 8'h24;
    localparam logic [7:0] ChEquals    = 8'h3D;
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChNewline   = 8'h0A;

    typedef enum logic [6:0] {
        PH_LINE_START   = 7'b0000001,
        PH_AFTER_DOLLAR = 7'b0000010,
        PH_KEY          = 7'b0000100,
        PH_PRE_QUOTE    = 7'b0001000,
        PH_QUOTED       = 7'b0010000,
        PH_SKIP_LINE    = 7'b0100000,
        PH_DONE         = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_ABORT    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] character;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
        phase_t     phase_next;
        logic       held_next;
    } step_t;

    function automatic logic is_ws(input logic [7:0] b);
        return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
    endfunction

endpackage

### rtl/core/dkvlp_step.sv
// Per-byte parser step: next phase, held backslash and up to two results.
module dkvlp_step (
    input  dkvlp_pkg::phase_t   phase,
    input  logic                held,
    input  logic [7:0]          byte_req,
    input  logic                end_of_input,
    output dkvlp_pkg::step_t    step
);

    always_comb
    begin
        step.num        = 2'd0;
        step.r0         = '{dkvlp_pkg::KIND_KEY, 8'h00, 1'b0};
        step.r1         = '{dkvlp_pkg::KIND_VALUE, byte_req, 1'b1};
        step.phase_next = phase;
        step.held_next  = held;

        if (phase == dkvlp_pkg::PH_DONE)
        begin
            step.num = 2'd0;
        end
        else if (end_of_input)
        begin
            if ((phase == dkvlp_pkg::PH_AFTER_DOLLAR) || (phase == dkvlp_pkg::PH_KEY) ||
                (phase == dkvlp_pkg::PH_PRE_QUOTE) || (phase == dkvlp_pkg::PH_QUOTED))
            begin
                step.num     = 2'd1;
                step.r0.kind = dkvlp_pkg::KIND_ABORT;
            end
            step.phase_next = dkvlp_pkg::PH_DONE;
            step.held_next  = 1'b0;
        end
        else
        begin
            unique case (phase)
                dkvlp_pkg::PH_LINE_START:
                begin
                    if (byte_req == dkvlp_pkg::ChDollar)
                        step.phase_next = dkvlp_pkg::PH_AFTER_DOLLAR;
                    else if (!dkvlp_pkg::is_ws(byte_req))
                        step.phase_next = dkvlp_pkg::PH_SKIP_LINE;
                end
                dkvlp_pkg::PH_AFTER_DOLLAR:
                begin
                    if (byte_req == dkvlp_pkg::ChNewline)
                        step.phase_next = dkvlp_pkg::PH_LINE_START;
                    else if (dkvlp_pkg::is_ws(byte_req))
                        step.phase_next = dkvlp_pkg::PH_SKIP_LINE;
                    else if (byte_req == dkvlp_pkg::ChEquals)
                        step.phase_next = dkvlp_pkg::PH_PRE_QUOTE;
                    else
                    begin
                        step.num          = 2'd1;
                        step.r0.character = byte_req;
                        step.phase_next   = dkvlp_pkg::PH_KEY;
                    end
                end
                dkvlp_pkg::PH_KEY:
                begin
                    if (byte_req == dkvlp_pkg::ChEquals)
                        step.phase_next = dkvlp_pkg::PH_PRE_QUOTE;
                    else if (!dkvlp_pkg::is_ws(byte_req))
                    begin
                        step.num          = 2'd1;
                        step.r0.character = byte_req;
                    end
                end
                dkvlp_pkg::PH_PRE_QUOTE:
                begin
                    if (byte_req == dkvlp_pkg::ChQuote)
                    begin
                        step.phase_next = dkvlp_pkg::PH_QUOTED;
                        step.held_next  = 1'b0;
                    end
                    else if (!dkvlp_pkg::is_ws(byte_req))
                    begin
                        step.num          = 2'd1;
                        step.r0.kind      = dkvlp_pkg::KIND_VALUE;
                        step.r0.character = byte_req;
                    end
                end
                dkvlp_pkg::PH_QUOTED:
                begin
                    step.r0.kind = dkvlp_pkg::KIND_VALUE;
                    if (held)
                    begin
                        step.num = 2'd1;
                        if (byte_req == dkvlp_pkg::ChQuote)
                        begin
                            step.r0.character = byte_req;
                            step.held_next    = 1'b0;
                        end
                        else if (byte_req == dkvlp_pkg::ChBackslash)
                            step.r0.character = dkvlp_pkg::ChBackslash;
                        else
                        begin
                            // held backslash plus this byte
                            step.num          = 2'd2;
                            step.r0.character = dkvlp_pkg::ChBackslash;
                            step.held_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        if (byte_req == dkvlp_pkg::ChQuote)
                        begin
                            step.num        = 2'd1;
                            step.r0.kind    = dkvlp_pkg::KIND_COMPLETE;
                            step.phase_next = dkvlp_pkg::PH_SKIP_LINE;
                        end
                        else if (byte_req == dkvlp_pkg::ChBackslash)
                            step.held_next = 1'b1;
                        else
                        begin
                            step.num          = 2'd1;
                            step.r0.character = byte_req;
                        end
                    end
                end
                dkvlp_pkg::PH_SKIP_LINE:
                begin
                    if (byte_req == dkvlp_pkg::ChNewline)
                        step.phase_next = dkvlp_pkg::PH_LINE_START;
                end
                default:
                begin
                    step.phase_next = dkvlp_pkg::PH_DONE;
                    step.held_next  = 1'b0;
                end
            endcase
        end

        step.r0.last = (step.num == 2'd1);
    end

endmodule

### rtl/core/dollar_key_value_line_parser_unit.sv
// Top level of the dollar key/value line parser: state registers and result queue.
// One byte is taken per cycle while in_ready is high. The parser step is a single
// pass of logic from the input port into a three-entry result queue; the results
// of a transaction are registered there and reach the output behind any results
// already queued. in_ready is high while the queue holds at most one result; with
// out_ready held high the block sustains one byte per cycle, and a byte that yields
// two results (a held backslash followed by an ordinary byte) drops in_ready while
// the queue drains. After end of input the block discards all bytes until reset.
module dollar_key_value_line_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_req,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  character,
    output logic        last
);

    dkvlp_pkg::phase_t  phase_reg, phase_next;
    logic               held_reg, held_next;
    logic [dkvlp_pkg::CntW-1:0] count_reg, count_next;
    dkvlp_pkg::result_t q_reg  [dkvlp_pkg::QDepth];
    dkvlp_pkg::result_t q_next [dkvlp_pkg::QDepth];
    dkvlp_pkg::step_t   step;

    logic push, pop;
    logic [dkvlp_pkg::CntW-1:0] base;

    dkvlp_step u_step (
        .phase        (phase_reg),
        .held         (held_reg),
        .byte_req     (byte_req),
        .end_of_input (end_of_input),
        .step         (step)
    );

    assign in_ready  = (count_reg <= dkvlp_pkg::CntW'(1));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - dkvlp_pkg::CntW'(pop);

    assign kind      = q_reg[0].kind;
    assign character = q_reg[0].character;
    assign last      = q_reg[0].last;

    always_comb
    begin
        phase_next = push ? step.phase_next : phase_reg;
        held_next  = push ? step.held_next : held_reg;
        count_next = base + (push ? dkvlp_pkg::CntW'(step.num) : '0);
        for (int i = 0; i < dkvlp_pkg::QDepth; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < dkvlp_pkg::QDepth - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < dkvlp_pkg::QDepth; i++)
        begin
            if (push && (step.num != 2'd0) && (dkvlp_pkg::CntW'(i) == base))
                q_next[i] = step.r0;
            if (push && (step.num == 2'd2) &&
                (dkvlp_pkg::CntW'(i) == base + dkvlp_pkg::CntW'(1)))
                q_next[i] = step.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dkvlp_pkg::PH_LINE_START;
            held_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dkvlp_pkg::QDepth; i++)
            q_reg[i] <= q_next[i];
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dkvlp_pkg::CntW'(dkvlp_pkg::QDepth))
        else $error("result queue overflow");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dkvlp_pkg::PH_DONE) |=> (phase_reg == dkvlp_pkg::PH_DONE))
        else $error("parser left done state before reset");

    a_held_quoted: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (phase_reg == dkvlp_pkg::PH_QUOTED))
        else $error("backslash held outside quotes");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((kind == dkvlp_pkg::KIND_COMPLETE) || (kind == dkvlp_pkg::KIND_ABORT)))
        |-> ((character == 8'h00) && last))
        else $error("record marker carries a byte or is not last");
`endif

endmodule
